// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check that is skipped while reset is asserted (active low).
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/bedt_pkg.sv =====
package bedt_pkg;

    // Field widths of the beats, the throttle setting and the entry phase.
    localparam int KIND_W = 2;
    localparam int ID_W   = 32;
    localparam int NOW_W  = 48;
    localparam int THR_W  = 16;
    localparam int PH_W   = 2;

    localparam logic [THR_W-1:0] THROTTLE_RESET = 16'd200;

    // Multiplicative hash of the block id, low 32 bits kept.
    localparam int              HASH_W   = 32;
    localparam logic [HASH_W-1:0] HASH_MUL = 32'd2654435761;

    // Remainder by a non power-of-two bucket count: a reciprocal multiply,
    // then a correction step.
    localparam int MOD_STEPS = 2;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    // Default geometry.
    localparam int DEF_BUCKETS   = 32;
    localparam int DEF_WAYS      = 4;
    localparam int DEF_TIME_BITS = 48;

    typedef enum logic [KIND_W-1:0] {
        K_START     = 2'd0,
        K_END       = 2'd1,
        K_ERR_CATCH = 2'd2,
        K_ERR       = 2'd3
    } t_kind;

    typedef enum logic [PH_W-1:0] {
        PH_NONE  = 2'd0,
        PH_START = 2'd1,
        PH_END   = 2'd2
    } t_phase;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;       // clear one bucket row
        logic load;      // capture the accepted input beat
        logic mul;       // register the hash product
        logic mod_step;  // one remainder step
        logic rd;        // read the bucket row
        logic eval;      // decide, write back, load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic mod_done;
        logic out_busy;
    } t_dp_sts;

endpackage

// ===== hw/rtl/bedt_if.sv =====
interface bedt_req_if;
    logic                         valid;
    logic                         ready;
    logic [bedt_pkg::KIND_W-1:0]  req_type;
    logic [bedt_pkg::ID_W-1:0]    block_id;
    logic [bedt_pkg::NOW_W-1:0]   now_ms;

    modport source (output valid, output req_type, output block_id, output now_ms,
                    input ready);
    modport sink   (input valid, input req_type, input block_id, input now_ms,
                    output ready);
endinterface

interface bedt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         emit;
    logic [bedt_pkg::KIND_W-1:0]  kind;
    logic [bedt_pkg::ID_W-1:0]    out_block_id;
    logic                         table_full;

    modport source (output valid, output emit, output kind, output out_block_id,
                    output table_full, input ready);
    modport sink   (input valid, input emit, input kind, input out_block_id,
                    input table_full, output ready);
endinterface

// ===== hw/rtl/bedt_ctrl.sv =====
module bedt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  bedt_pkg::t_dp_sts i_sts,
    output bedt_pkg::t_dp_cmd o_cmd
);
    import bedt_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_MOD   = 6'b001000,
        S_READ  = 6'b010000,
        S_EVAL  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.mul = 1'b1;
                n_state   = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                // Hold until the result register can take the new beat.
                if (!i_sts.out_busy) begin
                    o_cmd.eval = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bedt_dp.sv =====
module bedt_dp #(
    parameter int BUCKETS   = bedt_pkg::DEF_BUCKETS,
    parameter int WAYS      = bedt_pkg::DEF_WAYS,
    parameter int TIME_BITS = bedt_pkg::DEF_TIME_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bedt_pkg::t_dp_cmd             i_cmd,
    output bedt_pkg::t_dp_sts             o_sts,
    input  logic                          i_cfg_we,
    input  logic [bedt_pkg::THR_W-1:0]    i_cfg_wdata,
    input  logic [bedt_pkg::KIND_W-1:0]   i_req_type,
    input  logic [bedt_pkg::ID_W-1:0]     i_block_id,
    input  logic [bedt_pkg::NOW_W-1:0]    i_now_ms,
    input  logic                          i_rsp_ready,
    output logic                          o_rsp_valid,
    output logic                          o_emit,
    output logic [bedt_pkg::KIND_W-1:0]   o_kind,
    output logic [bedt_pkg::ID_W-1:0]     o_out_block_id,
    output logic                          o_table_full
);
    import bedt_pkg::*;

    localparam int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT_W   = 1 + ID_W + PH_W + TIME_BITS;
    localparam int QP_W    = 2 * HASH_W + 1;
    localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam logic [BW-1:0]     BUCK_LO  = BW'(BUCKETS);
    localparam logic [HASH_W-1:0] BUCK_MSK = HASH_W'(BUCKETS - 1);
    localparam logic [BW-1:0]     CLR_LAST = BW'(BUCKETS - 1);
    // Rounded-up reciprocal: the top bits of hash * RECIP give the exact quotient.
    localparam logic [HASH_W:0]   RECIP    = (HASH_W + 1)'(
        ((64'd1 << (HASH_W + BW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    // Row of one bucket: each way is {valid, id, phase, last time}.
    logic [WAYS-1:0][ENT_W-1:0] mem [BUCKETS];

    logic [THR_W-1:0]           r_throttle;
    logic [BW-1:0]              r_clr_addr;
    logic [KIND_W-1:0]          r_kind;
    logic [ID_W-1:0]            r_id;
    logic [NOW_W-1:0]           r_now;
    logic [HASH_W-1:0]          r_hash;
    logic [QP_W-1:0]            r_qprod;
    logic [BW-1:0]              r_rem;
    logic [MOD_CNT_W-1:0]       r_mod_cnt;
    logic [WAYS-1:0][ENT_W-1:0] r_row;

    logic                       r_out_valid;
    logic                       r_out_emit;
    logic [KIND_W-1:0]          r_out_kind;
    logic [ID_W-1:0]            r_out_id;
    logic                       r_out_full;

    logic [HASH_W-1:0]          w_prod;
    logic [BW-1:0]              w_quot;
    logic [BW-1:0]              w_qb;
    logic [BW-1:0]              n_rem;
    logic [BW-1:0]              w_bucket;
    logic [63:0]                w_now64;
    logic [TIME_BITS-1:0]       w_now;

    logic                       w_found;
    logic                       w_has_free;
    logic [WW-1:0]              w_hit_w;
    logic [WW-1:0]              w_free_w;
    logic [WW-1:0]              w_sel_w;
    logic                       w_sel_ok;
    logic [PH_W-1:0]            w_cur_phase;
    logic [TIME_BITS-1:0]       w_cur_last;
    logic [TIME_BITS-1:0]       w_elapsed;
    logic                       w_is_tab;
    logic                       w_emit;
    logic                       w_full;
    logic [PH_W-1:0]            w_new_phase;
    logic [TIME_BITS-1:0]       w_new_last;
    logic [WAYS-1:0][ENT_W-1:0] n_row;
    logic                       w_we;

    assign w_prod  = r_id * HASH_MUL;
    assign w_now64 = 64'(r_now);
    assign w_now   = w_now64[TIME_BITS-1:0];

    // The remainder is below 2^BW, so only the low BW bits of the quotient
    // and of hash - quotient * BUCKETS are needed.
    assign w_quot = r_qprod[HASH_W+BW +: BW];
    assign w_qb   = w_quot * BUCK_LO;
    assign n_rem  = r_hash[BW-1:0] - w_qb;

    assign w_bucket = IS_POW2 ? BW'(r_hash & BUCK_MSK) : r_rem;

    assign o_sts.clr_done = (r_clr_addr == CLR_LAST);
    assign o_sts.mod_done = IS_POW2 || (r_mod_cnt == MOD_CNT_W'(MOD_STEPS - 1));
    assign o_sts.out_busy = r_out_valid && !i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_throttle <= THROTTLE_RESET;
            r_clr_addr <= '0;
            r_mod_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_throttle <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + BW'(1);
            end
            if (i_cmd.mul) begin
                r_mod_cnt <= '0;
            end else if (i_cmd.mod_step) begin
                r_mod_cnt <= r_mod_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_req_type;
            r_id   <= i_block_id;
            r_now  <= i_now_ms;
        end
        if (i_cmd.mul) begin
            r_hash <= w_prod;
            r_rem  <= '0;
        end else if (i_cmd.mod_step && !IS_POW2) begin
            if (r_mod_cnt == '0) begin
                r_qprod <= QP_W'(r_hash) * QP_W'(RECIP);
            end else begin
                r_rem <= n_rem;
            end
        end
    end

    // Way lookup: lowest matching valid way, else lowest free way.
    always_comb begin
        w_found    = 1'b0;
        w_has_free = 1'b0;
        w_hit_w    = '0;
        w_free_w   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_row[w][ENT_W-1]) begin
                if (r_row[w][ENT_W-2 -: ID_W] == r_id) begin
                    w_found = 1'b1;
                    w_hit_w = WW'(w);
                end
            end else begin
                w_has_free = 1'b1;
                w_free_w   = WW'(w);
            end
        end
    end

    assign w_sel_w     = w_found ? w_hit_w : w_free_w;
    assign w_sel_ok    = w_found || w_has_free;
    assign w_cur_phase = w_found ? r_row[w_hit_w][TIME_BITS+PH_W-1 -: PH_W] : PH_NONE;
    assign w_cur_last  = w_found ? r_row[w_hit_w][TIME_BITS-1:0] : '0;
    assign w_elapsed   = w_now - w_cur_last;
    assign w_is_tab    = (r_kind == K_START) || (r_kind == K_END);

    always_comb begin
        w_emit      = 1'b0;
        w_full      = 1'b0;
        w_new_phase = w_cur_phase;
        w_new_last  = w_cur_last;
        if (!w_is_tab) begin
            w_emit = 1'b1;
        end else if (!w_sel_ok) begin
            w_full = 1'b1;
        end else if (r_kind == K_START) begin
            if (((w_cur_phase == PH_NONE) || (w_cur_phase == PH_END)) &&
                (w_elapsed >= TIME_BITS'(r_throttle))) begin
                w_emit      = 1'b1;
                w_new_phase = PH_START;
                w_new_last  = w_now;
            end
        end else begin
            if (w_cur_phase == PH_START) begin
                w_emit      = 1'b1;
                w_new_phase = PH_END;
                w_new_last  = w_now;
            end
        end
    end

    always_comb begin
        n_row          = r_row;
        n_row[w_sel_w] = {1'b1, r_id, w_new_phase, w_new_last};
    end

    assign w_we = i_cmd.eval && w_is_tab && w_sel_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_clr_addr] <= '0;
        end else if (w_we) begin
            mem[w_bucket] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_row <= mem[w_bucket];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.eval) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_out_emit <= w_emit;
            r_out_kind <= r_kind;
            r_out_id   <= r_id;
            r_out_full <= w_full;
        end
    end

    assign o_rsp_valid    = r_out_valid;
    assign o_emit         = r_out_emit;
    assign o_kind         = r_out_kind;
    assign o_out_block_id = r_out_id;
    assign o_table_full   = r_out_full;

endmodule

// ===== hw/rtl/block_event_dedup_throttle_table.sv =====
// Channel   Dir  Beat contents                          Handshake
// i_req     in   req_type, block_id, now_ms             valid/ready
// o_rsp     out  emit, kind, out_block_id, table_full   valid/ready
// i_cfg_*   in   throttle_ms (16 bit)                   write enable only
//
// Sequence: each event passes through accept, hash multiply, bucket remainder,
// row read and evaluate before the next one is accepted; when BUCKETS is not a
// power of two the remainder takes a reciprocal multiply step and a correction
// step. The evaluate step writes the bucket row back.
// Reset: synchronous, active low; afterwards a clearing pass over every bucket
// row empties the table, and no event is accepted until it ends.
// Stalls: a result waits in the output register; the next event is accepted
// meanwhile, and it stalls only at its evaluate step while that register holds a result not yet taken.
`include "assert_macros.svh"

module block_event_dedup_throttle_table #(
    parameter int BUCKETS   = bedt_pkg::DEF_BUCKETS,
    parameter int WAYS      = bedt_pkg::DEF_WAYS,
    parameter int TIME_BITS = bedt_pkg::DEF_TIME_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bedt_req_if.sink                   i_req,
    bedt_rsp_if.source                 o_rsp,
    input  logic                       i_cfg_we,
    input  logic [bedt_pkg::THR_W-1:0] i_cfg_wdata
);
    import bedt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller sequences one event at a time: clear pass after reset, then
    // accept, hash multiply, bucket remainder, row read and evaluate/write back.
    bedt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the throttle register, the hash and remainder unit, the
    // bucket row memory with its way lookup, and the result register.
    bedt_dp #(
        .BUCKETS   (BUCKETS),
        .WAYS      (WAYS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_type     (i_req.req_type),
        .i_block_id     (i_req.block_id),
        .i_now_ms       (i_req.now_ms),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (o_rsp.valid),
        .o_emit         (o_rsp.emit),
        .o_kind         (o_rsp.kind),
        .o_out_block_id (o_rsp.out_block_id),
        .o_table_full   (o_rsp.table_full)
    );

    // An accepted beat must start the hash step in the following cycle.
    `ASSERT_CLK_RST(a_accept_hash, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> w_cmd.mul, "accepted beat did not start hashing")

    // A result appears only after an evaluate step.
    `ASSERT_CLK_RST(a_out_from_eval, i_clk, i_rst_n, $rose(o_rsp.valid) |-> $past(w_cmd.eval), "result valid without evaluate")

    // The evaluate step never overwrites a result that is still waiting.
    `ASSERT_CLK_RST(a_no_overwrite, i_clk, i_rst_n, w_cmd.eval |-> !(o_rsp.valid && !o_rsp.ready), "result register overwritten")

    // A dropped event is never reported onward.
    `ASSERT_CLK(a_full_no_emit, i_clk, (i_rst_n && o_rsp.valid && o_rsp.table_full) |-> !o_rsp.emit, "full bucket event was emitted")

endmodule

// ===== tb/block_event_dedup_throttle_table_tb.sv =====
`timescale 1ns / 100ps

module block_event_dedup_throttle_table_tb;
    import bedt_pkg::*;

    // Geometry of the instance under test. The predictor below mirrors it exactly.
    localparam int TBL_BUCKETS   = 32;
    localparam int TBL_WAYS      = 4;
    localparam int TBL_TIME_BITS = 48;
    localparam int TBL_SLOTS     = TBL_BUCKETS * TBL_WAYS;

    // After every result has come back, a register write still lets the pipeline settle.
    localparam int SETTLE_CYCLES = 16;

    // Most random traffic goes to a handful of buckets with five ids each, so
    // every hot bucket fills up and its fifth id keeps running into a full table.
    localparam int HOT_BUCKETS = 8;
    localparam int IDS_PER_HOT = 5;
    localparam int HOT_IDS     = HOT_BUCKETS * IDS_PER_HOT;

    // One result beat as the block should produce it.
    typedef struct packed {
        logic            emit;
        t_kind           kind;
        logic [ID_W-1:0] block_id;
        logic            table_full;
    } t_outcome;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [THR_W-1:0] i_cfg_wdata;

    bedt_req_if req_bus ();
    bedt_rsp_if rsp_bus ();

    block_event_dedup_throttle_table #(
        .BUCKETS   (TBL_BUCKETS),
        .WAYS      (TBL_WAYS),
        .TIME_BITS (TBL_TIME_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: the throttle register and a private copy of the table.
    // Only valid entries are ever read, so the other arrays need no reset.
    logic [THR_W-1:0]         model_throttle;
    logic                     tbl_valid   [TBL_SLOTS];
    logic [ID_W-1:0]          tbl_id      [TBL_SLOTS];
    t_phase                   tbl_phase   [TBL_SLOTS];
    logic [TBL_TIME_BITS-1:0] tbl_last_ms [TBL_SLOTS];

    // Outcomes of accepted events, oldest first, waiting for their result beat.
    t_outcome pending_outcomes [$];

    int               mismatch_count = 0;
    int               src_gap_pct    = 0;
    int               sink_stall_pct = 0;
    logic [NOW_W-1:0] event_clock;
    logic [ID_W-1:0]  hot_ids [HOT_IDS];

    // Works out the result of one event and updates the table copy the way the
    // block does: look the id up in its bucket, allocate the first free way if it
    // is absent, then apply the start or end rules to the entry.
    function automatic t_outcome predict_outcome(t_kind kind, logic [ID_W-1:0] id,
                                                 logic [NOW_W-1:0] now_ms);
        t_outcome                 res;
        logic [HASH_W-1:0]        hash;
        logic [TBL_TIME_BITS-1:0] stamp;
        logic [TBL_TIME_BITS-1:0] elapsed;
        int                       base;
        int                       hit;
        int                       freeway;
        int                       w;
        res   = '{emit: 1'b0, kind: kind, block_id: id, table_full: 1'b0};
        stamp = now_ms[TBL_TIME_BITS-1:0];
        // Error reports bypass the table entirely.
        if (kind == K_ERR_CATCH || kind == K_ERR) begin
            res.emit = 1'b1;
            return res;
        end
        hash    = id * HASH_MUL;
        base    = int'(hash % TBL_BUCKETS) * TBL_WAYS;
        hit     = -1;
        freeway = -1;
        for (w = 0; w < TBL_WAYS; w++) begin
            if (tbl_valid[base + w]) begin
                if (hit < 0 && tbl_id[base + w] == id)
                    hit = base + w;
            end else if (freeway < 0) begin
                freeway = base + w;
            end
        end
        // A new entry starts with no phase and a last time of zero, so an early
        // start on it is throttled against time zero.
        if (hit < 0 && freeway >= 0) begin
            hit                = freeway;
            tbl_valid[hit]     = 1'b1;
            tbl_id[hit]        = id;
            tbl_phase[hit]     = PH_NONE;
            tbl_last_ms[hit]   = '0;
        end
        if (hit < 0) begin
            // Every way holds another id: the event is dropped, nothing changes.
            res.table_full = 1'b1;
        end else if (kind == K_START) begin
            if (tbl_phase[hit] == PH_NONE || tbl_phase[hit] == PH_END) begin
                // Elapsed time is taken modulo the time width, so it survives a wrap.
                elapsed = stamp - tbl_last_ms[hit];
                if (elapsed >= model_throttle) begin
                    tbl_phase[hit]   = PH_START;
                    tbl_last_ms[hit] = stamp;
                    res.emit         = 1'b1;
                end
            end
        end else if (tbl_phase[hit] == PH_START) begin
            tbl_phase[hit]   = PH_END;
            tbl_last_ms[hit] = stamp;
            res.emit         = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Sends one event beat. Valid is left high after the beat is taken; the next
    // call either keeps it high or drops it for a random gap at the next falling
    // edge, so valid never gets two assignments in one time step.
    task automatic send_event(t_kind kind, logic [ID_W-1:0] id, logic [NOW_W-1:0] now_ms);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < src_gap_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.block_id <= id;
        req_bus.now_ms   <= now_ms;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        pending_outcomes.push_back(predict_outcome(kind, id, now_ms));
    endtask

    // Stops sending and waits until every outstanding result has been checked,
    // then lets the pipeline settle.
    task automatic wait_idle();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The throttle register is only written while the block is idle.
    task automatic write_throttle(logic [THR_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        model_throttle = value;
    endtask

    // Walks one id through its whole life at the reset throttle of 200 ms, then
    // checks wrap of the time base and a bucket that runs out of ways.
    task automatic run_directed_lifecycle();
        logic [ID_W-1:0]  id_a;
        logic [ID_W-1:0]  id_c;
        logic [ID_W-1:0]  full_base;
        logic [NOW_W-1:0] t_max;
        int               k;
        id_a      = 32'h0000_0001;
        id_c      = 32'hFFFF_FFFF;
        full_base = 32'h5A5A_5A44;
        t_max     = '1;
        // Error kinds pass unconditionally, with the field extremes.
        send_event(K_ERR_CATCH, '0, '0);
        send_event(K_ERR, '1, t_max);
        // A fresh entry counts from time zero, so a start at 100 ms is held back.
        send_event(K_START, id_a, 48'd100);
        // An end with no start before it is suppressed.
        send_event(K_END, id_a, 48'd150);
        // Exactly the throttle interval has passed: reported.
        send_event(K_START, id_a, 48'd200);
        // A second start while already started is suppressed.
        send_event(K_START, id_a, 48'd500);
        send_event(K_END, id_a, 48'd501);
        // A second end is suppressed.
        send_event(K_END, id_a, 48'd502);
        // One millisecond short of the interval, then exactly on it.
        send_event(K_START, id_a, 48'd700);
        send_event(K_START, id_a, 48'd701);
        // Time wraps past its top: the elapsed time is taken modulo 2^48.
        send_event(K_START, id_c, t_max - 48'd10);
        send_event(K_END, id_c, t_max - 48'd5);
        send_event(K_START, id_c, 48'd193);
        send_event(K_START, id_c, 48'd194);
        // Ids that differ only above bit 4 share a bucket: four fill it, the
        // fifth and sixth find it full, and an id already in it still works.
        for (k = 0; k < 5; k++)
            send_event(K_START, full_base + 32'(k * 32), 48'h8000_0000_0000 + 48'(k));
        send_event(K_END, full_base + 32'(5 * 32), 48'h8000_0000_0010);
        send_event(K_END, full_base, 48'h8000_0000_0011);
    endtask

    // Both ends of the throttle range.
    task automatic run_throttle_extremes();
        // With no spacing at all even a fresh entry at time zero is reported.
        write_throttle('0);
        send_event(K_START, 32'h0000_0007, '0);
        send_event(K_END, 32'h0000_0007, '0);
        send_event(K_START, 32'h0000_0007, '0);
        // With the widest spacing the first start must wait the full 65535 ms.
        write_throttle('1);
        send_event(K_START, 32'h1234_5666, 48'd65534);
        send_event(K_START, 32'h1234_5666, 48'd65535);
        send_event(K_END, 32'h1234_5666, 48'd65536);
        send_event(K_START, 32'h1234_5666, 48'd131070);
    endtask

    // Random traffic: mostly start and end beats on the hot ids with the clock
    // moving in steps around the throttle interval, plus some long jumps, random
    // times, error beats and random ids as noise.
    task automatic run_random_traffic(int count, logic [THR_W-1:0] throttle,
                                      int gap_pct, int stall_pct);
        int              pick;
        t_kind           kind;
        logic [ID_W-1:0] id;
        write_throttle(throttle);
        src_gap_pct    = gap_pct;
        sink_stall_pct = stall_pct;
        repeat (count) begin
            pick = $urandom_range(99, 0);
            if (pick < 70)
                event_clock += $urandom_range(2 * throttle + 3, 0);
            else if (pick < 90)
                event_clock += $urandom_range(32'h000F_FFFF, 0);
            else
                event_clock = NOW_W'({$urandom, $urandom});
            pick = $urandom_range(99, 0);
            if (pick < 85) begin
                id   = hot_ids[$urandom_range(HOT_IDS - 1, 0)];
                pick = $urandom_range(99, 0);
                if (pick < 45)
                    kind = K_START;
                else if (pick < 88)
                    kind = K_END;
                else
                    kind = t_kind'($urandom_range(3, 2));
            end else begin
                id   = $urandom;
                kind = t_kind'($urandom_range(3, 0));
            end
            send_event(kind, id, event_clock);
        end
    endtask

    // The receiver stalls at random, at a rate set per phase.
    always @(negedge i_clk) begin
        rsp_bus.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    // Every result beat is checked against the oldest outstanding outcome.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected result beat", rsp_bus.out_block_id, '0);
            end else begin
                want = pending_outcomes.pop_front();
                if (rsp_bus.emit !== want.emit)
                    report_mismatch("emit", rsp_bus.emit, want.emit);
                if (rsp_bus.kind !== want.kind)
                    report_mismatch("kind", rsp_bus.kind, want.kind);
                if (rsp_bus.out_block_id !== want.block_id)
                    report_mismatch("out_block_id", rsp_bus.out_block_id, want.block_id);
                if (rsp_bus.table_full !== want.table_full)
                    report_mismatch("table_full", rsp_bus.table_full, want.table_full);
            end
        end
    end

    initial begin
        int i;
        req_bus.valid    = 1'b0;
        req_bus.req_type = K_START;
        req_bus.block_id = '0;
        req_bus.now_ms   = '0;
        rsp_bus.ready    = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        i_rst_n          = 1'b0;
        model_throttle   = THROTTLE_RESET;
        event_clock      = '0;
        for (i = 0; i < TBL_SLOTS; i++)
            tbl_valid[i] = 1'b0;
        // Hot ids: random upper bits, low five bits picking one of the hot buckets.
        for (i = 0; i < HOT_IDS; i++)
            hot_ids[i] = {27'($urandom), 5'(8 + (i % HOT_BUCKETS))};

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The block clears its table after reset; the handshake covers that wait.
        src_gap_pct    = 37;
        sink_stall_pct = 79;
        run_directed_lifecycle();
        run_throttle_extremes();
        run_random_traffic(460, THROTTLE_RESET, 37, 79);
        run_random_traffic(460, THR_W'($urandom_range(65535, 0)), 79, 37);
        run_random_traffic(460, THR_W'($urandom_range(40, 1)), 0, 0);
        wait_idle();

        if (mismatch_count == 0)
            $display("block_event_dedup_throttle_table_tb OK");
        else
            $display("block_event_dedup_throttle_table_tb NOT OK");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("block_event_dedup_throttle_table_tb NOT OK");
        $finish;
    end

endmodule
